@@ sv/mnae_pkg.sv @@
`default_nettype none
package mnae_pkg;

  localparam int NUM_SLOTS_DEF = 26;
  localparam int MAX_DIM       = 8;
  localparam int DATA_WIDTH    = 32;
  localparam int FRAC_BITS     = 16;

  localparam int DIM_W  = 4;
  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int CELLS  = MAX_DIM * MAX_DIM;
  localparam int CELL_W = 2 * IDX_W;
  localparam int ACC_W  = 2 * DATA_WIDTH + IDX_W + 1;

  typedef enum logic [3:0] {
    OP_DEFINE = 4'd0,
    OP_LOAD   = 4'd1,
    OP_ADD    = 4'd2,
    OP_SUB    = 4'd3,
    OP_COPY   = 4'd4,
    OP_NEGATE = 4'd5,
    OP_MUL    = 4'd6,
    OP_SLICE  = 4'd7,
    OP_READ   = 4'd8,
    OP_DELETE = 4'd9
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_SIZE      = 3'd2,
    ST_INCOMPAT  = 3'd3,
    ST_RANGE     = 3'd4,
    ST_FULL      = 3'd5,
    ST_BAD_DIM   = 3'd6,
    ST_NO_LOAD   = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_EL_A,
    S_EL_B,
    S_EL_OP,
    S_MUL,
    S_ACC,
    S_FIN,
    S_COMMIT,
    S_RD_DATA,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [3:0]        opcode;
    logic [7:0]        dest_name;
    logic [7:0]        src_a_name;
    logic [7:0]        src_b_name;
    logic [DIM_W-1:0]  row_lo;
    logic [DIM_W-1:0]  row_hi;
    logic [DIM_W-1:0]  col_lo;
    logic [DIM_W-1:0]  col_hi;
    logic signed [31:0] load_value;
    logic              clear_all;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic [DIM_W-1:0]   rows;
    logic [DIM_W-1:0]   cols;
  } result_t;

  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

  // Clamp a wide signed value into the element width.
  function automatic logic [DATA_WIDTH-1:0] sat_data(input logic signed [ACC_W-1:0] v);
    logic [DATA_WIDTH-1:0] r;
    if (v > SAT_MAX) begin
      r = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else if (v < SAT_MIN) begin
      r = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      r = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/named_matrix_arithmetic_engine_unit.sv @@
`default_nettype none
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_stall_o | in_data_i  (mnae_pkg::cmd_t)
// out     | output    | out_valid_o/out_stall_i | out_data_o (mnae_pkg::result_t)
//
// One command is taken at a time; in_stall_o stays high until its result moves into the
// output register, which happens once that register is empty or being taken.
// Every command first scans the slot table, one slot a cycle, then passes through the
// check state. Elementwise ops then step each element through S_EL_A, S_EL_B and S_EL_OP;
// multiply steps each product term through S_EL_A, S_EL_B, S_MUL and S_ACC, then S_FIN per
// element, through the one shared multiplier; writing a result copies all CELLS scratch
// entries into the element memory.
// Reset clears slot valid bits and the pending load; element memory holds no reset.
// A stalled result holds in the output register until out_stall_i drops.
module named_matrix_arithmetic_engine_unit #(
  parameter int NUM_SLOTS = mnae_pkg::NUM_SLOTS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire mnae_pkg::cmd_t   in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output mnae_pkg::result_t     out_data_o
);

  localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int EAW   = SW + mnae_pkg::CELL_W;
  localparam int DW    = mnae_pkg::DATA_WIDTH;
  localparam int DIM_W = mnae_pkg::DIM_W;
  localparam int IDX_W = mnae_pkg::IDX_W;
  localparam int ACC_W = mnae_pkg::ACC_W;
  localparam int CW    = mnae_pkg::CELL_W;

  mnae_pkg::state_e state_q, state_d;
  mnae_pkg::cmd_t   cmd_q;
  mnae_pkg::result_t res_q;
  mnae_pkg::result_t chk_res;
  mnae_pkg::result_t out_q;
  logic             out_valid_q;
  logic             out_load;

  // slot table
  logic             valid_q [NUM_SLOTS];
  logic [7:0]       names_q [NUM_SLOTS];
  logic [DIM_W-1:0] rows_q  [NUM_SLOTS];
  logic [DIM_W-1:0] cols_q  [NUM_SLOTS];

  // lookup results
  logic [SW-1:0]    scan_q;
  logic             fa_q, fb_q, fd_q, ff_q;
  logic [SW-1:0]    ia_q, ib_q, id_q, if_q;
  logic [DIM_W-1:0] ra_q, ca_q, rb_q, cb_q;

  // element loop
  logic [SW-1:0]    dst_q;
  logic [DIM_W-1:0] rn_q, cn_q, kn_q, offr_q, offc_q;
  logic [DIM_W-1:0] r_q, c_q, k_q;
  logic signed [DW-1:0]    a_q;
  logic signed [2*DW-1:0]  prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic             zero_q;
  logic [CW:0]      cm_q;
  logic             cm_wr_q;
  logic [CW-1:0]    cm_cell_q;

  // pending load
  logic             pend_q;
  logic [SW-1:0]    lslot_q;
  logic [DIM_W-1:0] lrow_q, lcol_q, lrows_q, lcols_q;

  // memories
  logic             e_we, s_we;
  logic [EAW-1:0]   e_waddr, e_raddr;
  logic [DW-1:0]    e_wdata, e_rdata, s_wdata, s_rdata;
  logic [CW-1:0]    s_waddr, s_raddr;

  mnae_ram #(.WIDTH(DW), .DEPTH(NUM_SLOTS * mnae_pkg::CELLS)) u_elem (
    .clk_i(clk_i), .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  mnae_ram #(.WIDTH(DW), .DEPTH(mnae_pkg::CELLS)) u_scratch (
    .clk_i(clk_i), .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  logic is_mul, is_unary, last_slot, last_el, last_k, dok;
  logic [SW-1:0] dslot;
  logic [DIM_W-1:0] ar_sum, ac_sum;
  logic [IDX_W-1:0] a_row, a_col, b_row, b_col;
  logic [SW-1:0]    b_slot;
  logic signed [DW:0] el_wide;
  logic [DW-1:0] el_val, fin_val;
  logic bad_dim, slice_bad, cm_out;

  assign is_mul    = (cmd_q.opcode == mnae_pkg::OP_MUL);
  assign is_unary  = (cmd_q.opcode == mnae_pkg::OP_COPY) ||
                     (cmd_q.opcode == mnae_pkg::OP_NEGATE) ||
                     (cmd_q.opcode == mnae_pkg::OP_SLICE);
  assign last_slot = (scan_q == SW'(NUM_SLOTS - 1));
  assign last_el   = (c_q == cn_q - 1'b1) && (r_q == rn_q - 1'b1);
  assign last_k    = (k_q == kn_q - 1'b1);
  assign dok       = fd_q || ff_q;
  assign dslot     = fd_q ? id_q : if_q;
  assign bad_dim   = (cmd_q.row_hi == '0) || (cmd_q.row_hi > DIM_W'(mnae_pkg::MAX_DIM)) ||
                     (cmd_q.col_hi == '0) || (cmd_q.col_hi > DIM_W'(mnae_pkg::MAX_DIM));
  assign slice_bad = !((cmd_q.row_lo < cmd_q.row_hi) && (cmd_q.row_hi <= ra_q) &&
                       (cmd_q.col_lo < cmd_q.col_hi) && (cmd_q.col_hi <= ca_q));

  // Move the result into the output register once that register is free or being taken.
  assign out_load  = (state_q == mnae_pkg::S_RESP) && (!out_valid_q || !out_stall_i);

  // Operand addressing: multiply walks row of A and column of B over k.
  assign ar_sum = r_q + offr_q;
  assign ac_sum = c_q + offc_q;
  assign a_row  = ar_sum[IDX_W-1:0];
  assign a_col  = is_mul ? k_q[IDX_W-1:0] : ac_sum[IDX_W-1:0];
  assign b_slot = is_unary ? ia_q : ib_q;
  assign b_row  = is_unary ? a_row : (is_mul ? k_q[IDX_W-1:0] : r_q[IDX_W-1:0]);
  assign b_col  = is_unary ? a_col : c_q[IDX_W-1:0];

  always_comb begin
    unique case (cmd_q.opcode)
      mnae_pkg::OP_ADD:    el_wide = {a_q[DW-1], a_q} + {e_rdata[DW-1], e_rdata};
      mnae_pkg::OP_SUB:    el_wide = {a_q[DW-1], a_q} - {e_rdata[DW-1], e_rdata};
      mnae_pkg::OP_NEGATE: el_wide = '0 - {a_q[DW-1], a_q};
      default:             el_wide = {a_q[DW-1], a_q};
    endcase
  end
  assign el_val  = mnae_pkg::sat_data({{(ACC_W-DW-1){el_wide[DW]}}, el_wide});
  assign fin_val = mnae_pkg::sat_data(acc_q >>> mnae_pkg::FRAC_BITS);

  // Cells outside the new size are written as zero; define zeroes everything.
  assign cm_out = zero_q || ({1'b0, cm_cell_q[CW-1:IDX_W]} >= rn_q) ||
                  ({1'b0, cm_cell_q[IDX_W-1:0]} >= cn_q);

  always_comb begin
    e_we    = 1'b0;
    e_waddr = {dst_q, cm_cell_q};
    e_wdata = cm_out ? '0 : s_rdata;
    if (state_q == mnae_pkg::S_COMMIT && cm_wr_q) begin
      e_we = 1'b1;
    end else if (state_q == mnae_pkg::S_CHECK && cmd_q.opcode == mnae_pkg::OP_LOAD && pend_q) begin
      e_we    = 1'b1;
      e_waddr = {lslot_q, lrow_q[IDX_W-1:0], lcol_q[IDX_W-1:0]};
      e_wdata = cmd_q.load_value;
    end
    unique case (state_q)
      mnae_pkg::S_EL_B: e_raddr = {b_slot, b_row, b_col};
      mnae_pkg::S_CHECK: e_raddr = {ia_q, cmd_q.row_lo[IDX_W-1:0], cmd_q.col_lo[IDX_W-1:0]};
      default:          e_raddr = {ia_q, a_row, a_col};
    endcase
    s_we    = (state_q == mnae_pkg::S_EL_OP) || (state_q == mnae_pkg::S_FIN);
    s_waddr = {r_q[IDX_W-1:0], c_q[IDX_W-1:0]};
    s_wdata = (state_q == mnae_pkg::S_FIN) ? fin_val : el_val;
    s_raddr = cm_q[CW-1:0];
  end

  // Result of commands that finish at the check; later states overwrite it otherwise.
  always_comb begin
    chk_res = '0;
    unique case (cmd_q.opcode)
      mnae_pkg::OP_DEFINE:
        if (bad_dim) chk_res.status = mnae_pkg::ST_BAD_DIM;
        else if (!dok) chk_res.status = mnae_pkg::ST_FULL;
      mnae_pkg::OP_LOAD:
        if (!pend_q) chk_res.status = mnae_pkg::ST_NO_LOAD;
        else begin
          chk_res.rows = lrows_q; chk_res.cols = lcols_q;
        end
      mnae_pkg::OP_ADD, mnae_pkg::OP_SUB, mnae_pkg::OP_MUL:
        if (!fa_q || !fb_q) chk_res.status = mnae_pkg::ST_NOT_FOUND;
        else if (is_mul && ca_q != rb_q) chk_res.status = mnae_pkg::ST_INCOMPAT;
        else if (!is_mul && (ra_q != rb_q || ca_q != cb_q)) chk_res.status = mnae_pkg::ST_SIZE;
        else if (!dok) chk_res.status = mnae_pkg::ST_FULL;
      mnae_pkg::OP_COPY, mnae_pkg::OP_NEGATE, mnae_pkg::OP_SLICE:
        if (!fa_q) chk_res.status = mnae_pkg::ST_NOT_FOUND;
        else if (cmd_q.opcode == mnae_pkg::OP_SLICE && slice_bad)
          chk_res.status = mnae_pkg::ST_RANGE;
        else if (!dok) chk_res.status = mnae_pkg::ST_FULL;
      mnae_pkg::OP_READ:
        if (!fa_q) chk_res.status = mnae_pkg::ST_NOT_FOUND;
        else if (cmd_q.row_lo >= ra_q || cmd_q.col_lo >= ca_q)
          chk_res.status = mnae_pkg::ST_RANGE;
      mnae_pkg::OP_DELETE:
        if (!cmd_q.clear_all) begin
          if (!fa_q) chk_res.status = mnae_pkg::ST_NOT_FOUND;
          else begin
            chk_res.rows = ra_q; chk_res.cols = ca_q;
          end
        end
      default: chk_res = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mnae_pkg::S_IDLE:   if (in_valid_i) state_d = mnae_pkg::S_SCAN;
      mnae_pkg::S_SCAN:   if (last_slot) state_d = mnae_pkg::S_CHECK;
      mnae_pkg::S_CHECK: begin
        state_d = mnae_pkg::S_RESP;
        unique case (cmd_q.opcode)
          mnae_pkg::OP_DEFINE:
            if (!bad_dim && dok) state_d = mnae_pkg::S_COMMIT;
          mnae_pkg::OP_ADD, mnae_pkg::OP_SUB, mnae_pkg::OP_MUL:
            if (fa_q && fb_q && dok &&
                (is_mul ? (ca_q == rb_q) : (ra_q == rb_q && ca_q == cb_q)))
              state_d = mnae_pkg::S_EL_A;
          mnae_pkg::OP_COPY, mnae_pkg::OP_NEGATE:
            if (fa_q && dok) state_d = mnae_pkg::S_EL_A;
          mnae_pkg::OP_SLICE:
            if (fa_q && !slice_bad && dok) state_d = mnae_pkg::S_EL_A;
          mnae_pkg::OP_READ:
            if (fa_q && cmd_q.row_lo < ra_q && cmd_q.col_lo < ca_q) state_d = mnae_pkg::S_RD_DATA;
          default: state_d = mnae_pkg::S_RESP;
        endcase
      end
      mnae_pkg::S_EL_A:  state_d = mnae_pkg::S_EL_B;
      mnae_pkg::S_EL_B:  state_d = is_mul ? mnae_pkg::S_MUL : mnae_pkg::S_EL_OP;
      mnae_pkg::S_EL_OP: state_d = last_el ? mnae_pkg::S_COMMIT : mnae_pkg::S_EL_A;
      mnae_pkg::S_MUL:   state_d = mnae_pkg::S_ACC;
      mnae_pkg::S_ACC:   state_d = last_k ? mnae_pkg::S_FIN : mnae_pkg::S_EL_A;
      mnae_pkg::S_FIN:   state_d = last_el ? mnae_pkg::S_COMMIT : mnae_pkg::S_EL_A;
      mnae_pkg::S_COMMIT:
        if (cm_q == (CW+1)'(mnae_pkg::CELLS)) state_d = mnae_pkg::S_RESP;
      mnae_pkg::S_RD_DATA: state_d = mnae_pkg::S_RESP;
      mnae_pkg::S_RESP:  if (out_load) state_d = mnae_pkg::S_IDLE;
      default:           state_d = mnae_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mnae_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      cm_wr_q     <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) valid_q[i] <= 1'b0;
    end else begin
      cm_wr_q <= (state_q == mnae_pkg::S_COMMIT) && (cm_q < (CW+1)'(mnae_pkg::CELLS));
      // hold a stalled result, drop it once taken unless a new one replaces it
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      if (state_q == mnae_pkg::S_CHECK) begin
        if (cmd_q.opcode == mnae_pkg::OP_LOAD && pend_q &&
            lcol_q == lcols_q - 1'b1 && lrow_q == lrows_q - 1'b1) begin
          pend_q <= 1'b0;
        end
        if (cmd_q.opcode == mnae_pkg::OP_DELETE) begin
          if (cmd_q.clear_all) begin
            for (int i = 0; i < NUM_SLOTS; i++) valid_q[i] <= 1'b0;
            pend_q <= 1'b0;
          end else if (fa_q) begin
            valid_q[ia_q] <= 1'b0;
            if (lslot_q == ia_q) pend_q <= 1'b0;
          end
        end
      end
      if (state_q == mnae_pkg::S_COMMIT && state_d == mnae_pkg::S_RESP) begin
        valid_q[dst_q] <= 1'b1;
        if (zero_q) pend_q <= 1'b1;
        else if (lslot_q == dst_q) pend_q <= 1'b0;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (state_q == mnae_pkg::S_IDLE && in_valid_i) begin
      cmd_q  <= in_data_i;
      scan_q <= '0;
      fa_q <= 1'b0; fb_q <= 1'b0; fd_q <= 1'b0; ff_q <= 1'b0;
    end
    if (state_q == mnae_pkg::S_SCAN) begin
      if (valid_q[scan_q]) begin
        if (!fa_q && names_q[scan_q] == cmd_q.src_a_name) begin
          fa_q <= 1'b1; ia_q <= scan_q; ra_q <= rows_q[scan_q]; ca_q <= cols_q[scan_q];
        end
        if (!fb_q && names_q[scan_q] == cmd_q.src_b_name) begin
          fb_q <= 1'b1; ib_q <= scan_q; rb_q <= rows_q[scan_q]; cb_q <= cols_q[scan_q];
        end
        if (!fd_q && names_q[scan_q] == cmd_q.dest_name) begin
          fd_q <= 1'b1; id_q <= scan_q;
        end
      end else if (!ff_q) begin
        ff_q <= 1'b1; if_q <= scan_q;
      end
      scan_q <= scan_q + 1'b1;
    end

    if (state_q == mnae_pkg::S_CHECK) begin
      dst_q  <= dslot;
      r_q    <= '0; c_q <= '0; k_q <= '0;
      acc_q  <= '0;
      cm_q   <= '0;
      zero_q <= (cmd_q.opcode == mnae_pkg::OP_DEFINE);
      offr_q <= '0; offc_q <= '0;
      kn_q   <= ca_q;
      if (cmd_q.opcode == mnae_pkg::OP_DEFINE) begin
        rn_q <= cmd_q.row_hi; cn_q <= cmd_q.col_hi;
      end else if (cmd_q.opcode == mnae_pkg::OP_MUL) begin
        rn_q <= ra_q; cn_q <= cb_q;
      end else if (cmd_q.opcode == mnae_pkg::OP_SLICE) begin
        rn_q <= cmd_q.row_hi - cmd_q.row_lo; cn_q <= cmd_q.col_hi - cmd_q.col_lo;
        offr_q <= cmd_q.row_lo; offc_q <= cmd_q.col_lo;
      end else begin
        rn_q <= ra_q; cn_q <= ca_q;
      end
      if (cmd_q.opcode == mnae_pkg::OP_LOAD && pend_q) begin
        if (lcol_q == lcols_q - 1'b1) begin
          lcol_q <= '0; lrow_q <= lrow_q + 1'b1;
        end else begin
          lcol_q <= lcol_q + 1'b1;
        end
      end
      res_q <= chk_res;
    end

    if (state_q == mnae_pkg::S_EL_B) a_q <= e_rdata;
    if (state_q == mnae_pkg::S_MUL) prod_q <= a_q * $signed(e_rdata);
    if (state_q == mnae_pkg::S_ACC) begin
      acc_q <= acc_q + {{(ACC_W-2*DW){prod_q[2*DW-1]}}, prod_q};
      k_q   <= last_k ? '0 : k_q + 1'b1;
    end
    if (state_q == mnae_pkg::S_EL_OP || state_q == mnae_pkg::S_FIN) begin
      acc_q <= '0;
      if (c_q == cn_q - 1'b1) begin
        c_q <= '0; r_q <= r_q + 1'b1;
      end else begin
        c_q <= c_q + 1'b1;
      end
    end

    if (state_q == mnae_pkg::S_COMMIT) begin
      cm_cell_q <= cm_q[CW-1:0];
      if (cm_q < (CW+1)'(mnae_pkg::CELLS)) cm_q <= cm_q + 1'b1;
      if (state_d == mnae_pkg::S_RESP) begin
        names_q[dst_q] <= cmd_q.dest_name;
        rows_q[dst_q]  <= rn_q;
        cols_q[dst_q]  <= cn_q;
        res_q.status   <= mnae_pkg::ST_OK;
        res_q.rows     <= rn_q;
        res_q.cols     <= cn_q;
        if (zero_q) begin
          lslot_q <= dst_q; lrow_q <= '0; lcol_q <= '0;
          lrows_q <= rn_q;  lcols_q <= cn_q;
        end
      end
    end

    if (state_q == mnae_pkg::S_RD_DATA) begin
      res_q.read_value <= e_rdata;
      res_q.rows       <= ra_q;
      res_q.cols       <= ca_q;
    end

    if (out_load) out_q <= res_q;
  end

  assign in_stall_o  = (state_q != mnae_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed or dropped");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == mnae_pkg::S_SCAN)
    else $error("accepted transaction did not start slot scan");

  a_commit_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cm_wr_q |-> state_q == mnae_pkg::S_COMMIT)
    else $error("commit write outside commit");

  a_pend_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && state_q == mnae_pkg::S_IDLE) |-> valid_q[lslot_q])
    else $error("pending load targets an empty slot");

endmodule
`default_nettype wire

@@ sv/mnae_ram.sv @@
`default_nettype none
module mnae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire
